@@ src/insertion_sorter_unit_assert.svh @@
// Assertion macros shared by the insertion sorter RTL.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef INSERTION_SORTER_UNIT_ASSERT_SVH
`define INSERTION_SORTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define ISU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("insertion_sorter_unit: assertion failed");
`define ISU_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("insertion_sorter_unit: reset assertion failed");
`else
`define ISU_ASSERT(label, prop)
`define ISU_ASSERT_RST(label, prop)
`endif

`endif

@@ src/isort_pkg.sv @@
// Shared types and constants for the insertion sorter.
// No dependencies; used by isort_cell and insertion_sorter_unit.
`timescale 1ns / 1ps
`default_nettype none
package isort_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic   ins_en;    // insert din into the sorted chain
    logic   drain_en;  // shift the chain one place toward cell 0
    value_t din;       // value being inserted
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ src/insertion_sorter_unit.sv @@
// Insertion sorter: each value is inserted in place; after the final item, one result per cycle while not stalled.
// Throughput: one value per cycle while not draining; a set of values then drains with ready low.
// Each insert updates every cell of the chain at once, so the cell chain sets the rate.
// Reset (rst, synchronous, active high) empties the chain and clears the overflow flag.
// Depends on isort_pkg, isort_cell and insertion_sorter_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "insertion_sorter_unit_assert.svh"
module insertion_sorter_unit
  import isort_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Input stream of values to be sorted.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value (signed)
  input  logic               s_axis_tlast,   // final_item
  // Output stream of sorted values.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [VALUE_W-1:0] m_axis_tdata,   // [31:0] sorted_value (signed)
  output logic               m_axis_tlast,   // run_end
  output logic               m_axis_tuser    // [0] overflow
);

  // The sorted store is a chain of CAPACITY cells kept in ascending order,
  // with valid bits forming a contiguous run starting at cell 0. An insert
  // broadcasts the new value; every greater entry moves up one cell and the
  // new value drops into the gap, all in the same update.

  logic              draining;
  logic              dropped;
  cell_ctl_t         ctl;
  logic              in_xfer;
  logic              out_xfer;
  logic              full;
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_greater;
  value_t            cell_value [CAPACITY];

  // While a set drains, no new transaction is taken on the input side.
  assign s_axis_tready = !draining;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  // The top cell holding an entry means the store is full.
  assign full          = cell_valid[CAPACITY-1];

  // Values that arrive while full are dropped and only mark the overflow.
  assign ctl.ins_en   = in_xfer && !full;
  assign ctl.drain_en = out_xfer;
  assign ctl.din      = s_axis_tdata;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   p_valid;
    logic   p_greater;
    value_t p_value;
    logic   n_valid;
    value_t n_value;

    if (i == 0) begin : g_first
      assign p_valid   = 1'b1;
      assign p_greater = 1'b0;
      assign p_value   = '0;
    end else begin : g_mid
      assign p_valid   = cell_valid[i-1];
      assign p_greater = cell_greater[i-1];
      assign p_value   = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_below
      assign n_valid = cell_valid[i+1];
      assign n_value = cell_value[i+1];
    end

    isort_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .prev_valid   (p_valid),
      .prev_greater (p_greater),
      .prev_value   (p_value),
      .next_valid   (n_valid),
      .next_value   (n_value),
      .valid        (cell_valid[i]),
      .greater      (cell_greater[i]),
      .value        (cell_value[i])
    );
  end

  // Results come straight from cell 0, which is a register; the chain only
  // shifts when the downstream side takes a transaction, so a stall holds
  // every output steady. The last result is the one with no entry above it.
  assign m_axis_tvalid = draining && cell_valid[0];
  assign m_axis_tdata  = cell_value[0];
  assign m_axis_tlast  = !cell_valid[1];
  assign m_axis_tuser  = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      if (in_xfer && full) begin
        dropped <= 1'b1;
      end
      if (in_xfer && s_axis_tlast) begin
        draining <= 1'b1;
      end
      if (out_xfer && m_axis_tlast) begin
        draining <= 1'b0;
        dropped  <= 1'b0;
      end
    end
  end

  // Occupied cells always form one run starting at cell 0.
  `ISU_ASSERT(a_valid_run, ((cell_valid >> 1) & ~cell_valid) == '0)
  // A drain never finds the chain empty.
  `ISU_ASSERT(a_drain_nonempty, draining |-> cell_valid[0])
  // An accepted value that fits grows the store by exactly one entry.
  `ISU_ASSERT(a_fill_step,
    (in_xfer && !full) |=> $countones(cell_valid) == $past($countones(cell_valid)) + 1)
  // Reset leaves an empty, idle chain.
  `ISU_ASSERT_RST(a_reset_empty, rst |=> (!draining && cell_valid == '0 && !dropped))

  for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order_chk
    // Neighboring entries stay in ascending order.
    `ISU_ASSERT(a_ascending, cell_valid[j+1] |-> (cell_value[j] <= cell_value[j+1]))
  end

endmodule
`default_nettype wire

@@ src/isort_cell.sv @@
// One cell of the systolic insertion chain: holds one sorted entry.
// Depends on isort_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isort_cell
  import isort_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      prev_valid,    // lower neighbor holds an entry
  input  logic      prev_greater,  // lower neighbor moves up on this insert
  input  value_t    prev_value,
  input  logic      next_valid,    // upper neighbor holds an entry
  input  value_t    next_value,
  output logic      valid,
  output logic      greater,
  output value_t    value
);

  logic take;

  // A stored entry strictly greater than the new value moves up one place.
  assign greater = valid && (value > ctl.din);
  // The first empty cell above the valid run also takes a value.
  assign take = greater || (!valid && prev_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain_en) begin
      valid <= next_valid;
    end else if (ctl.ins_en && take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.drain_en) begin
      value <= next_value;
    end else if (ctl.ins_en && take) begin
      value <= prev_greater ? prev_value : ctl.din;
    end
  end

endmodule
`default_nettype wire
